@@ rtl/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helper functions for the sentence
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  localparam int unsigned LenSat = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_START  = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_NO_TERM   = 3'd3,
    ST_MISMATCH  = 3'd4
  } status_e;

  // Running state of the line being received.
  typedef struct packed {
    logic        started;
    logic        star_seen;
    logic [7:0]  running_xor;
    logic [2:0]  kept_length;
    logic [23:0] last_three;
    logic [7:0]  comma_tally;
  } line_t;

  // One verdict.
  typedef struct packed {
    logic [7:0] separator_count;
    logic [7:0] computed_checksum;
    status_e    status;
  } verdict_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    hex_digit = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c inside {[8'h61:8'h7A]}) ? (c - 8'h20) : c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/nsc_line_tracker.sv @@
// ----------------------------------------------------------------------------
// nsc_line_tracker
// Holds the state of the line in progress and works out its next value
// from each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_line_tracker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_line_i,
  output nsc_pkg::line_t     line_nxt_o,
  output nsc_pkg::line_t     line_q_o
);
  import nsc_pkg::*;

  line_t line_q, line_d, upd;
  logic  kept;

  always_comb begin
    upd  = line_q;
    kept = (data_byte_i != ChCr) && (data_byte_i != ChLf);
    if (kept) begin
      if (!line_q.started) begin
        if (data_byte_i == ChDollar) begin
          upd.started     = 1'b1;
          upd.kept_length = 3'd1;
          upd.last_three  = {line_q.last_three[15:0], data_byte_i};
        end
      end else begin
        upd.last_three = {line_q.last_three[15:0], data_byte_i};
        if (line_q.kept_length < 3'(LenSat)) begin
          upd.kept_length = line_q.kept_length + 3'd1;
        end
        if (!line_q.star_seen) begin
          if (data_byte_i == ChStar) begin
            upd.star_seen = 1'b1;
          end else begin
            upd.running_xor = line_q.running_xor ^ data_byte_i;
            if (data_byte_i == ChComma && line_q.comma_tally != 8'hFF) begin
              upd.comma_tally = line_q.comma_tally + 8'd1;
            end
          end
        end
      end
    end
    // The state starts afresh once a line has been judged.
    line_d = end_of_line_i ? '0 : upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (accept_i) begin
      line_q <= line_d;
    end
  end

  assign line_nxt_o = upd;
  assign line_q_o   = line_q;

endmodule

`default_nettype wire

@@ rtl/nsc_verdict.sv @@
// ----------------------------------------------------------------------------
// nsc_verdict
// Judges a finished line: start mark, length, terminator and checksum pair.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_verdict (
  input  wire nsc_pkg::line_t line_i,
  output nsc_pkg::verdict_t   verdict_o
);
  import nsc_pkg::*;

  logic [7:0] mark, hi, lo;
  logic       pair_bad;

  always_comb begin
    mark     = line_i.last_three[23:16];
    hi       = upcase(line_i.last_three[15:8]);
    lo       = upcase(line_i.last_three[7:0]);
    // A checksum with the top bit set never matches a two-digit pair.
    pair_bad = line_i.running_xor[7]
            || (hi != hex_digit(line_i.running_xor[7:4]))
            || (lo != hex_digit(line_i.running_xor[3:0]));

    verdict_o.computed_checksum = line_i.started ? line_i.running_xor : 8'h00;
    verdict_o.separator_count   = line_i.started ? line_i.comma_tally : 8'h00;
    if (!line_i.started) begin
      verdict_o.status = ST_NO_START;
    end else if (line_i.kept_length < 3'(LenSat)) begin
      verdict_o.status = ST_TOO_SHORT;
    end else if (mark != ChStar) begin
      verdict_o.status = ST_NO_TERM;
    end else if (pair_bad) begin
      verdict_o.status = ST_MISMATCH;
    end else begin
      verdict_o.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nmea_sentence_checker.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Checks the framing and checksum of received NMEA 0183 lines byte by byte.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one received character per beat in tdata, with
// tlast set on the last character of a line. Carriage return and line feed
// characters are ignored, as is anything before the first dollar sign.
// On the beat that carries tlast the block judges the line and presents a
// single verdict beat on the master channel through its output register: a
// status code, the XOR checksum it computed and the number of commas before
// the asterisk. Beats without tlast produce no output.
// One character is taken in every cycle while tready on the slave side is high.
// Verdicts go to an output register backed by a one-entry skid stage, so
// the slave side keeps flowing while a verdict waits; tready on the slave
// side drops only once both hold a verdict the receiver has not taken.
// Reset clears the line state and discards any pending verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side. tdata: [7:0] data_byte. tlast: end_of_line.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tlast_i,
  // Master side. tdata: [2:0] status, [10:3] computed_checksum,
  // [18:11] separator_count, [23:19] zero.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o
);
  import nsc_pkg::*;

  line_t    line_nxt, line_q;
  verdict_t verdict;

  logic     s_acc, m_acc, push;
  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  verdict_t out_q, out_d, skid_q, skid_d;

  assign s_axis_tready_o = !skid_valid_q;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc           = out_valid_q && m_axis_tready_i;
  assign push            = s_acc && s_axis_tlast_i;

  nsc_line_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (s_acc),
    .data_byte_i   (s_axis_tdata_i),
    .end_of_line_i (s_axis_tlast_i),
    .line_nxt_o    (line_nxt),
    .line_q_o      (line_q)
  );

  nsc_verdict u_verdict (
    .line_i    (line_nxt),
    .verdict_o (verdict)
  );

  // Output register plus skid stage. A new verdict goes straight to the
  // output register when it is free or being emptied this cycle, and to the
  // skid stage otherwise.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (m_acc) begin
      out_valid_d = skid_valid_q;
      out_d       = skid_q;
      skid_valid_d = 1'b0;
    end
    if (push) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_d       = verdict;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = verdict;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q.separator_count, out_q.computed_checksum,
                            out_q.status};

  // The skid stage only ever fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a verdict while the output register is empty");

  // After a line has been judged its state starts afresh.
  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (line_q == '0))
    else $error("line state not cleared after a verdict");

  // A line without a start mark reports no checksum and no commas.
  a_no_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_NO_START) |->
      (out_q.computed_checksum == 8'h00 && out_q.separator_count == 8'h00))
    else $error("no-start verdict carries data");

  // A byte without tlast never creates a verdict.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !m_acc) |=> ($stable(out_valid_q) && $stable(skid_valid_q)))
    else $error("verdict count changed without a line end or a take");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NMEA sentence checker: feeds received lines as
// character beats, predicts each verdict and compares it with the master side.
// ----------------------------------------------------------------------------
// A queue of character beats is filled phase by phase by the stimulus process.
// A clocked driver presents them on the slave channel. Every accepted beat is
// run through a behavioural copy of the checker, and each line end adds one
// verdict to a queue of outstanding verdicts. A clocked monitor takes the
// verdict beats and checks every field against the oldest outstanding one.
// Both sides back off at random, in three phases with different duty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nsc_pkg::*;

  // Cycles without any accepted beat before the run is abandoned. The worst
  // legitimate gap comes only from random back-off, so this is generous.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;

  // One character beat as it goes to the slave channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } char_beat_t;

  // One verdict as the checker should report it.
  typedef struct packed {
    status_e    status;
    logic [7:0] checksum;
    logic [7:0] commas;
  } line_verdict_t;

  // Running state of the line being predicted.
  typedef struct packed {
    logic        started;
    logic        star_seen;
    logic [7:0]  sum;
    logic [2:0]  kept;
    logic [23:0] tail;
    logic [7:0]  commas;
  } line_state_t;

  typedef logic [7:0] char_list_t[$];

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  char_beat_t    char_q[$];
  line_verdict_t verdict_q[$];
  char_beat_t    tx_next;
  line_state_t   line_st = '0;

  int unsigned tx_idle_pct  = 20;
  int unsigned rx_stall_pct = 55;
  int unsigned chars_queued = 0;
  int unsigned lines_queued = 0;
  int unsigned verdicts_seen = 0;
  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned status_tally[5] = '{default: 0};

  nmea_sentence_checker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)    // [2:0] status, [10:3] checksum,
                                       // [18:11] commas, [23:19] zero
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Line checker prediction
  // --------------------------------------------------------------------------

  function automatic logic [7:0] ascii_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  // Uppercase hex character of one nibble.
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  // Folds one accepted character into the line state; on a line end the
  // verdict is queued and the state starts afresh.
  task automatic absorb_char(input logic [7:0] ch, input logic eol);
    line_verdict_t v;
    logic [7:0]    mark;
    logic [7:0]    hi;
    logic [7:0]    lo;
    // Carriage return and line feed never reach the line state, even when
    // they carry the line end.
    if (ch != ChCr && ch != ChLf) begin
      if (!line_st.started) begin
        // Everything ahead of the first dollar sign is discarded.
        if (ch == ChDollar) begin
          line_st.started = 1'b1;
          line_st.kept    = 3'd1;
          line_st.tail    = {line_st.tail[15:0], ch};
        end
      end else begin
        line_st.tail = {line_st.tail[15:0], ch};
        if (line_st.kept < 3'd4) line_st.kept = line_st.kept + 3'd1;
        // Only the span up to the first asterisk is summed; a second dollar
        // sign in it is plain data.
        if (!line_st.star_seen) begin
          if (ch == ChStar) begin
            line_st.star_seen = 1'b1;
          end else begin
            line_st.sum = line_st.sum ^ ch;
            if (ch == ChComma && line_st.commas != 8'hFF) begin
              line_st.commas = line_st.commas + 8'd1;
            end
          end
        end
      end
    end
    if (eol) begin
      mark = line_st.tail[23:16];
      hi   = ascii_upper(line_st.tail[15:8]);
      lo   = ascii_upper(line_st.tail[7:0]);
      if (!line_st.started) begin
        v.status = ST_NO_START;
      end else if (line_st.kept < 3'd4) begin
        v.status = ST_TOO_SHORT;
      end else if (mark != ChStar) begin
        v.status = ST_NO_TERM;
      end else if (line_st.sum[7] || hi != nibble_char(line_st.sum[7:4]) ||
                   lo != nibble_char(line_st.sum[3:0])) begin
        // A sum above 7Fh can never match, whatever the pair says.
        v.status = ST_MISMATCH;
      end else begin
        v.status = ST_OK;
      end
      v.checksum = line_st.started ? line_st.sum : 8'h00;
      v.commas   = line_st.started ? line_st.commas : 8'h00;
      verdict_q.push_back(v);
      status_tally[v.status] = status_tally[v.status] + 1;
      line_st = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Slave side driver
  // --------------------------------------------------------------------------

  // A beat leaves the queue only when the channel is free, so tvalid and
  // tdata stay put while the block holds tready low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_char(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          tx_next = char_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_next.ch;
          s_axis_tlast  <= tx_next.eol;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Master side: back-pressure, verdict check and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    line_verdict_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        verdicts_seen = verdicts_seen + 1;
        if (verdict_q.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= MaxReports) begin
            $display("tb_top: unexpected verdict beat %h", m_axis_tdata);
          end
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[2:0] !== want.status || m_axis_tdata[10:3] !== want.checksum ||
              m_axis_tdata[18:11] !== want.commas || m_axis_tdata[23:19] !== 5'd0) begin
            error_count = error_count + 1;
            if (error_count <= MaxReports) begin
              $display("tb_top: verdict %0d: want status %0d sum %h commas %0d, got %h",
                       verdicts_seen, want.status, want.checksum, want.commas, m_axis_tdata);
              $display("tb_top:   got status %0d sum %h commas %0d pad %h",
                       m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[18:11],
                       m_axis_tdata[23:19]);
            end
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("tb_top: no beat moved for %0d cycles, %0d verdicts outstanding",
                 idle_cycles, verdict_q.size());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Queues a line, with the line end on its final character.
  task automatic queue_line(input char_list_t s);
    char_beat_t b;
    foreach (s[i]) begin
      b.ch  = s[i];
      b.eol = (i == s.size() - 1);
      char_q.push_back(b);
    end
    chars_queued = chars_queued + s.size();
    lines_queued = lines_queued + 1;
  endtask

  // Builds one random line. Most are well formed sentences with random
  // content; the rest are damaged sentences, truncated ones and plain noise.
  task automatic queue_random_line();
    char_list_t  s;
    logic [7:0]  c;
    logic [7:0]  sum;
    int unsigned kind;
    int unsigned r;
    int unsigned star_at;
    int unsigned cut;
    kind = $urandom_range(99);
    sum  = 8'h00;
    s    = {};
    if (kind >= 85) begin
      // Noise: any byte at all, biased towards the characters that matter.
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(7);
        case (r)
          0: c = ChDollar;
          1: c = ChStar;
          2: c = ChComma;
          3: c = ($urandom_range(1) != 0) ? ChCr : ChLf;
          default: c = 8'($urandom_range(255));
        endcase
        s.push_back(c);
      end
      queue_line(s);
      return;
    end
    // Occasional junk ahead of the start mark.
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        c = 8'($urandom_range(255));
        if (c == ChDollar) c = 8'h00;
        s.push_back(c);
      end
    end
    s.push_back(ChDollar);
    repeat ($urandom_range(0, 8)) begin
      r = $urandom_range(15);
      if (r < 4) begin
        c = ChComma;
      end else if (r == 4) begin
        c = 8'($urandom_range(128, 255));
      end else if (r == 5) begin
        c = ChDollar;
      end else if (r == 6) begin
        c = ($urandom_range(1) != 0) ? ChCr : ChLf;
      end else begin
        c = 8'($urandom_range(32, 126));
        if (c == ChStar) c = 8'h41;
      end
      if (c != ChCr && c != ChLf) sum = sum ^ c;
      s.push_back(c);
    end
    star_at = s.size();
    s.push_back(ChStar);
    c = nibble_char(sum[7:4]);
    if (c > 8'h40 && $urandom_range(1) != 0) c = c + 8'h20;
    s.push_back(c);
    c = nibble_char(sum[3:0]);
    if (c > 8'h40 && $urandom_range(1) != 0) c = c + 8'h20;
    s.push_back(c);
    if (kind >= 60 && kind < 75) begin
      // Damage: a wrong checksum digit, a lost asterisk or a stray trailer.
      r = $urandom_range(2);
      if (r == 0) begin
        s[s.size() - 1] = s[s.size() - 1] ^ (8'h01 << $urandom_range(7));
      end else if (r == 1) begin
        s[star_at] = 8'($urandom_range(43, 126));
      end else begin
        s.push_back(8'($urandom_range(32, 126)));
      end
    end else if (kind >= 75) begin
      cut = $urandom_range(1, s.size());
      while (s.size() > cut) s.delete(s.size() - 1);
    end
    // Line ending: none, CR alone, or CR LF; the line end rides on the last.
    r = $urandom_range(2);
    if (r >= 1) s.push_back(ChCr);
    if (r == 2) s.push_back(ChLf);
    queue_line(s);
  endtask

  // Holds the stimulus back until every line sent so far has its verdict.
  task automatic drain();
    while (char_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    char_list_t s;
    // Directed lines: lone junk, the shortest good sentence, a sum with the
    // top bit set and a lowercase pair, a good sentence ended on CR, a second
    // dollar sign with no terminator, and a sentence cut off after the asterisk.
    queue_line('{8'hFF});
    queue_line('{ChDollar, ChStar, 8'h30, 8'h30});
    queue_line('{ChDollar, 8'hFF, ChStar, 8'h66, 8'h66});
    queue_line('{ChDollar, 8'h61, ChStar, 8'h36, 8'h31, ChCr});
    queue_line('{ChDollar, ChDollar, ChComma, ChStar});
    queue_line('{ChDollar, ChStar});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender idles lightly, receiver stalls hard.
    tx_idle_pct  = 20;
    rx_stall_pct = 55;
    while (chars_queued < 80) queue_random_line();
    drain();

    // Phase two: the other way round.
    tx_idle_pct  = 55;
    rx_stall_pct = 20;
    while (chars_queued < 130) queue_random_line();
    drain();

    // Phase three: full rate on both sides, ending with a long run of commas
    // so that the comma count saturates.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (chars_queued < 180) queue_random_line();
    s = {ChDollar};
    repeat (260) s.push_back(ChComma);
    s.push_back(ChStar);
    s.push_back(8'h30);
    s.push_back(8'h30);
    s.push_back(ChCr);
    s.push_back(ChLf);
    queue_line(s);
    drain();

    // Allow time for any stray verdict to appear.
    repeat (8) @(posedge clk_i);

    $display("tb_top: %0d characters in %0d lines, %0d verdicts checked",
             chars_queued, lines_queued, verdicts_seen);
    $display("tb_top: ok %0d, no start %0d, too short %0d, no terminator %0d, mismatch %0d",
             status_tally[ST_OK], status_tally[ST_NO_START], status_tally[ST_TOO_SHORT],
             status_tally[ST_NO_TERM], status_tally[ST_MISMATCH]);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d errors", error_count);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/nsc_pkg.sv
rtl/nsc_line_tracker.sv
rtl/nsc_verdict.sv
rtl/nmea_sentence_checker.sv
sim/tb_top.sv
